/* hw/rtl/htfr_pkg.sv */
// ----------------------------------------------------------------------------
// htfr_pkg
// Shared types, constants and the hex digit decoder of the telemetry frame
// receiver.
// ----------------------------------------------------------------------------
package htfr_pkg;

    localparam logic [7:0] SEPARATOR = 8'h3B;

    // Millivolts per raw count in unsigned 4.16 fixed point.
    localparam int unsigned SCALE_W     = 20;
    localparam int unsigned PROD_W      = 16 + SCALE_W;
    localparam logic [SCALE_W-1:0] CELL1_SCALE = 20'd685146;
    localparam logic [SCALE_W-1:0] TOTAL_SCALE = 20'd689750;

    localparam int unsigned WORD_COUNT = 5;
    localparam int unsigned WORD_SPAN  = 4 * WORD_COUNT;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_CHECKSUM = 2'd1,
        ST_WRONG_LENGTH = 2'd2
    } status_t;

    // Only '0'..'9' and 'A'..'F' carry a value; every other character is zero.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

endpackage

/* hw/rtl/hex_telemetry_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// hex_telemetry_frame_receiver_top
// Collects hex telemetry lines closed by ';', checks length and checksum,
// and emits decoded battery voltages, speeds and distance totals.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata: rx_byte
// m_*       out        m_tvalid/m_tready  tuser: status; tdata: decoded fields
//
// A byte is held in the input register and updates the line state when it
// leaves it. A ';' loads the decode register at that same edge, then the
// multiply register and the output register in turn, each one loading when
// the stage after it is empty or moving.
// A byte can be accepted in every cycle unless a ';' waits in the input register for a full decode register; each stage
// moves on as soon as the stage after it is empty or moving, so bytes that give no result keep
// flowing while a result waits at the output.
// Reset clears the line counter, the totals and all valid bits, and sets the checksum to its seed of 1.
// ----------------------------------------------------------------------------
module hex_telemetry_frame_receiver_top #(
    parameter int unsigned MSG_LEN = 23,
    parameter int unsigned BUF_LEN = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [1:0]   m_tuser,   // [1:0] status
    // [19:0] cell1_mv, [40:20] cell2_mv, [56:41] speed_left,
    // [72:57] speed_right, [104:73] distance_left, [136:105] distance_right,
    // [152:137] sequence_word, [159:153] zero
    output logic [159:0] m_tdata
);

    localparam int unsigned STORE_DEPTH =
        (MSG_LEN - 1 > htfr_pkg::WORD_SPAN) ? MSG_LEN - 1 : htfr_pkg::WORD_SPAN;
    localparam int unsigned IDX_W  = $clog2(STORE_DEPTH);
    localparam int unsigned PW     = htfr_pkg::PROD_W;
    localparam int unsigned SW     = htfr_pkg::SCALE_W;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Line state.
    logic [7:0] frame_store_reg [STORE_DEPTH];
    logic [6:0] byte_count_reg;
    logic [6:0] byte_count_next;
    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic [31:0] left_total_reg;
    logic [31:0] right_total_reg;

    // Decode register.
    logic                 dec_valid_reg;
    htfr_pkg::status_t    dec_status_reg;
    htfr_pkg::status_t    dec_status_next;
    logic [15:0]          dec_word_reg [htfr_pkg::WORD_COUNT];
    logic [15:0]          dec_word_next [htfr_pkg::WORD_COUNT];

    // Multiply register.
    logic                 mul_valid_reg;
    htfr_pkg::status_t    mul_status_reg;
    logic [PW-1:0]        mul_p1_reg;
    logic [PW-1:0]        mul_pt_reg;
    logic [15:0]          mul_sl_reg;
    logic [15:0]          mul_sr_reg;
    logic [15:0]          mul_seq_reg;
    logic [31:0]          mul_dl_reg;
    logic [31:0]          mul_dr_reg;

    // Output register.
    logic                 out_valid_reg;
    htfr_pkg::status_t    out_status_reg;
    logic [19:0]          out_c1_reg;
    logic [20:0]          out_c2_reg;
    logic [15:0]          out_sl_reg;
    logic [15:0]          out_sr_reg;
    logic [31:0]          out_dl_reg;
    logic [31:0]          out_dr_reg;
    logic [15:0]          out_seq_reg;

    logic        out_ready;
    logic        mul_ready;
    logic        dec_ready;
    logic        in_is_sep;
    logic        in_fire;
    logic        dec_load;
    logic        mul_load;
    logic        mul_load_ok;
    logic [6:0]  count_inc;
    logic [3:0]  nib [STORE_DEPTH];
    logic [7:0]  check_byte;
    logic [31:0] left_total_next;
    logic [31:0] right_total_next;
    logic [19:0] c1_val;
    logic [19:0] tot_val;

    assign out_ready = !out_valid_reg || m_tready;
    assign mul_ready = !mul_valid_reg || out_ready;
    assign dec_ready = !dec_valid_reg || mul_ready;
    assign in_is_sep = (in_byte_reg == htfr_pkg::SEPARATOR);
    assign in_fire   = in_valid_reg && (!in_is_sep || dec_ready);
    assign s_tready  = !in_valid_reg || in_fire;
    assign dec_load  = in_fire && in_is_sep;
    assign mul_load  = dec_valid_reg && mul_ready;
    assign mul_load_ok = mul_load && (dec_status_reg == htfr_pkg::ST_OK);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Line stage: counter, checksum and stored characters.
    assign count_inc = byte_count_reg + 7'd1;

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        if (in_fire)
        begin
            if (in_is_sep)
            begin
                byte_count_next  = 7'd0;
                running_sum_next = 8'd1;
            end
            else if (count_inc >= 7'(BUF_LEN))
            begin
                byte_count_next  = 7'd0;
                running_sum_next = 8'd1;
            end
            else
            begin
                byte_count_next = count_inc;
                if (byte_count_reg < 7'(MSG_LEN - 3))
                begin
                    running_sum_next = running_sum_reg + in_byte_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= 7'd0;
            running_sum_reg <= 8'd1;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !in_is_sep && byte_count_reg < 7'(STORE_DEPTH))
        begin
            frame_store_reg[byte_count_reg[IDX_W-1:0]] <= in_byte_reg;
        end
    end

    // Frame check and word decode.
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            nib[i] = htfr_pkg::hex_nibble(frame_store_reg[i]);
        end
    end

    assign check_byte = {nib[MSG_LEN-3], nib[MSG_LEN-2]};

    always_comb
    begin
        if (byte_count_reg != 7'(MSG_LEN - 1))
        begin
            dec_status_next = htfr_pkg::ST_WRONG_LENGTH;
        end
        else if (check_byte != running_sum_reg)
        begin
            dec_status_next = htfr_pkg::ST_BAD_CHECKSUM;
        end
        else
        begin
            dec_status_next = htfr_pkg::ST_OK;
        end
        for (int w = 0; w < htfr_pkg::WORD_COUNT; w++)
        begin
            if (dec_status_next == htfr_pkg::ST_OK)
            begin
                dec_word_next[w] = {nib[4*w], nib[4*w+1], nib[4*w+2], nib[4*w+3]};
            end
            else
            begin
                dec_word_next[w] = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else if (dec_ready)
        begin
            dec_valid_reg <= dec_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_load)
        begin
            dec_status_reg <= dec_status_next;
            dec_word_reg   <= dec_word_next;
        end
    end

    // Multiply stage and distance totals.
    assign left_total_next  = left_total_reg + {16'd0, dec_word_reg[2]};
    assign right_total_next = right_total_reg + {16'd0, dec_word_reg[3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_total_reg  <= 32'd0;
            right_total_reg <= 32'd0;
            mul_valid_reg   <= 1'b0;
        end
        else
        begin
            if (mul_load_ok)
            begin
                left_total_reg  <= left_total_next;
                right_total_reg <= right_total_next;
            end
            if (mul_ready)
            begin
                mul_valid_reg <= mul_load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            mul_status_reg <= dec_status_reg;
            mul_p1_reg     <= PW'(dec_word_reg[0]) * PW'(htfr_pkg::CELL1_SCALE);
            mul_pt_reg     <= PW'(dec_word_reg[1]) * PW'(htfr_pkg::TOTAL_SCALE);
            mul_sl_reg     <= dec_word_reg[2];
            mul_sr_reg     <= dec_word_reg[3];
            mul_seq_reg    <= dec_word_reg[4];
            mul_dl_reg     <= mul_load_ok ? left_total_next : 32'd0;
            mul_dr_reg     <= mul_load_ok ? right_total_next : 32'd0;
        end
    end

    // Output stage.
    assign c1_val  = mul_p1_reg[PW-1:PW-SW];
    assign tot_val = mul_pt_reg[PW-1:PW-SW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_valid_reg && out_ready)
        begin
            out_status_reg <= mul_status_reg;
            out_c1_reg     <= c1_val;
            out_c2_reg     <= {1'b0, tot_val} - {1'b0, c1_val};
            out_sl_reg     <= mul_sl_reg;
            out_sr_reg     <= mul_sr_reg;
            out_dl_reg     <= mul_dl_reg;
            out_dr_reg     <= mul_dr_reg;
            out_seq_reg    <= mul_seq_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_seq_reg, out_dr_reg, out_dl_reg, out_sr_reg,
                       out_sl_reg, out_c2_reg, out_c1_reg};

    // A line is never allowed to grow to the buffer length.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < 7'(BUF_LEN))
        else $error("line counter reached the buffer length");

    // A fresh line always starts with the checksum seed.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg == 7'd0 |-> running_sum_reg == 8'd1)
        else $error("checksum not reseeded at line start");

    // Distance totals move only when a good frame enters the multiply stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        !mul_load_ok |=> $stable(left_total_reg) && $stable(right_total_reg))
        else $error("distance totals changed without a good frame");

    // A rejected frame carries an all-zero payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != htfr_pkg::ST_OK |-> m_tdata == 160'd0)
        else $error("rejected frame has nonzero payload");

    // A result is only ever produced for a separator that went through.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dec_valid_reg) |-> $past(in_valid_reg) && $past(in_is_sep))
        else $error("decode stage loaded without a separator");

endmodule

/* bench/hex_telemetry_frame_receiver_top_tb.sv */
// ----------------------------------------------------------------------------
// hex_telemetry_frame_receiver_top_tb
// Drives telemetry bytes into the receiver and checks every decoded report
// against a line tracker kept in the bench. Good frames, checksum errors,
// short and long lines, non-hex characters and overlong lines are sent,
// first as directed cases and then as random traffic, with idle cycles on
// both sides of the stream.
// ----------------------------------------------------------------------------
module hex_telemetry_frame_receiver_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_LEN  = 23;
    localparam int unsigned LINE_LIMIT = 64;
    localparam int unsigned CSUM_POS   = FRAME_LEN - 3;
    localparam longint unsigned CELL1_MV_PER_COUNT = 685146;
    localparam longint unsigned TOTAL_MV_PER_COUNT = 689750;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 10;
    localparam int RANDOM_BYTES = 520;

    typedef logic [15:0] words_t [5];

    typedef struct packed {
        htfr_pkg::status_t status;
        logic [19:0] cell1_mv;
        logic [20:0] cell2_mv;
        logic [15:0] speed_left;
        logic [15:0] speed_right;
        logic [31:0] distance_left;
        logic [31:0] distance_right;
        logic [15:0] sequence_word;
    } report_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [1:0]   m_tuser;
    logic [159:0] m_tdata;

    report_t    expected_reports [$];
    logic [7:0] line_buf [$];

    logic [7:0]  line_bytes [LINE_LIMIT];
    logic [6:0]  line_len = 7'd0;
    logic [7:0]  line_sum = 8'd1;
    logic [31:0] left_dist = 32'd0;
    logic [31:0] right_dist = 32'd0;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int bytes_sent = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int n_ok = 0;
    int n_bad_sum = 0;
    int n_wrong_len = 0;
    int n_dropped = 0;

    hex_telemetry_frame_receiver_top #(
        .MSG_LEN(FRAME_LEN),
        .BUF_LEN(LINE_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser(m_tuser),
        .m_tdata(m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return 4'(c - 8'h30);
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return 4'(c - 8'h41 + 8'd10);
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_pair_at(input int pos);
        return {digit_value(line_bytes[pos]), digit_value(line_bytes[pos + 1])};
    endfunction

    function automatic logic [15:0] hex_word_at(input int pos);
        return {hex_pair_at(pos), hex_pair_at(pos + 2)};
    endfunction

    task automatic track_rx_byte(input logic [7:0] b);
        report_t r;
        logic [63:0] c1;
        logic [63:0] tot;
        r = '0;
        if (b != htfr_pkg::SEPARATOR)
        begin
            if (line_len < LINE_LIMIT)
            begin
                line_bytes[line_len[5:0]] = b;
            end
            if (line_len < CSUM_POS)
            begin
                line_sum = line_sum + b;
            end
            line_len = line_len + 7'd1;
            if (line_len >= LINE_LIMIT)
            begin
                line_len = 7'd0;
                line_sum = 8'd1;
                n_dropped++;
            end
        end
        else
        begin
            if (int'(line_len) + 1 != FRAME_LEN)
            begin
                r.status = htfr_pkg::ST_WRONG_LENGTH;
                n_wrong_len++;
            end
            else if (hex_pair_at(CSUM_POS) != line_sum)
            begin
                r.status = htfr_pkg::ST_BAD_CHECKSUM;
                n_bad_sum++;
            end
            else
            begin
                c1  = (64'(hex_word_at(0)) * CELL1_MV_PER_COUNT) >> 16;
                tot = (64'(hex_word_at(4)) * TOTAL_MV_PER_COUNT) >> 16;
                r.speed_left     = hex_word_at(8);
                r.speed_right    = hex_word_at(12);
                r.sequence_word  = hex_word_at(16);
                left_dist        = left_dist + 32'(r.speed_left);
                right_dist       = right_dist + 32'(r.speed_right);
                r.status         = htfr_pkg::ST_OK;
                r.cell1_mv       = 20'(c1);
                r.cell2_mv       = 21'(tot - c1);
                r.distance_left  = left_dist;
                r.distance_right = right_dist;
                n_ok++;
            end
            expected_reports.push_back(r);
            line_len = 7'd0;
            line_sum = 8'd1;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            track_rx_byte(s_tdata);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : report_check
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("report transfer with nothing expected, tuser 0x%0h", m_tuser);
                error_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("cell1_mv", 32'(want.cell1_mv), 32'(m_tdata[19:0]));
                check_field("cell2_mv", 32'(want.cell2_mv), 32'(m_tdata[40:20]));
                check_field("speed_left", 32'(want.speed_left), 32'(m_tdata[56:41]));
                check_field("speed_right", 32'(want.speed_right), 32'(m_tdata[72:57]));
                check_field("distance_left", want.distance_left, m_tdata[104:73]);
                check_field("distance_right", want.distance_right, m_tdata[136:105]);
                check_field("sequence_word", 32'(want.sequence_word),
                            32'(m_tdata[152:137]));
                check_field("pad", 32'd0, 32'(m_tdata[159:153]));
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("hex_telemetry_frame_receiver_top test failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
        begin
            send_byte(line_buf[i]);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (lower ? 8'h57 : 8'h37) + 8'(n);
    endfunction

    function automatic logic [7:0] random_non_separator();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == htfr_pkg::SEPARATOR)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic words_t random_words();
        words_t w;
        for (int k = 0; k < 5; k++)
        begin
            case ($urandom_range(0, 9))
                0:       w[k] = 16'h0000;
                1:       w[k] = 16'hFFFF;
                default: w[k] = 16'($urandom_range(0, 65535));
            endcase
        end
        return w;
    endfunction

    task automatic make_frame(input words_t words, input int odd_pct, input bit lower,
                              input bit bad_sum);
        logic [7:0] c;
        logic [7:0] sum;
        line_buf.delete();
        sum = 8'd1;
        for (int k = 0; k < 5; k++)
        begin
            for (int d = 0; d < 4; d++)
            begin
                c = hex_char(words[k][15 - 4 * d -: 4], lower);
                if ($urandom_range(0, 99) < odd_pct)
                begin
                    c = random_non_separator();
                end
                line_buf.push_back(c);
                sum = sum + c;
            end
        end
        if (bad_sum)
        begin
            sum = sum ^ 8'(1 << $urandom_range(0, 7));
        end
        line_buf.push_back(hex_char(sum[7:4], 1'b0));
        line_buf.push_back(hex_char(sum[3:0], 1'b0));
        line_buf.push_back(htfr_pkg::SEPARATOR);
    endtask

    task automatic test_good_frames();
        make_frame('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 0, 1'b0, 1'b0);
        send_line();
        make_frame('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, 1'b0, 1'b0);
        send_line();
        make_frame('{16'hFFFF, 16'h0000, 16'h1234, 16'hABCD, 16'h0001}, 0, 1'b0, 1'b0);
        send_line();
        make_frame('{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFE}, 0, 1'b0, 1'b0);
        send_line();
    endtask

    task automatic test_odd_characters();
        make_frame('{16'hABCD, 16'hEF01, 16'hFACE, 16'hBEEF, 16'hC0DE}, 0, 1'b1, 1'b0);
        send_line();
        make_frame('{16'h1A2B, 16'h3C4D, 16'h5E6F, 16'h7A8B, 16'h9C0D}, 40, 1'b0, 1'b0);
        send_line();
    endtask

    task automatic test_bad_checksum();
        make_frame('{16'h4000, 16'h8000, 16'h0100, 16'h0200, 16'h0042}, 0, 1'b0, 1'b1);
        send_line();
    endtask

    task automatic test_wrong_length();
        line_buf.delete();
        line_buf.push_back(htfr_pkg::SEPARATOR);
        send_line();
        line_buf.delete();
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        line_buf.push_back(htfr_pkg::SEPARATOR);
        send_line();
        line_buf.delete();
        repeat (FRAME_LEN - 2) line_buf.push_back(8'h41);
        line_buf.push_back(htfr_pkg::SEPARATOR);
        send_line();
        line_buf.delete();
        repeat (FRAME_LEN) line_buf.push_back(8'h30);
        line_buf.push_back(htfr_pkg::SEPARATOR);
        send_line();
    endtask

    task automatic test_overlong_line();
        line_buf.delete();
        repeat (LINE_LIMIT) line_buf.push_back(8'h35);
        send_line();
        make_frame('{16'h0800, 16'h1000, 16'h0010, 16'h0020, 16'h0003}, 0, 1'b0, 1'b0);
        send_line();
        line_buf.delete();
        repeat (LINE_LIMIT - 1) line_buf.push_back(8'h41);
        line_buf.push_back(htfr_pkg::SEPARATOR);
        send_line();
    endtask

    task automatic test_random_traffic(input int byte_budget);
        int stop_at;
        int pick;
        stop_at = bytes_sent + byte_budget;
        wait_for_drain();
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                make_frame(random_words(), ($urandom_range(0, 3) == 0) ? 5 : 0,
                           ($urandom_range(0, 4) == 0), 1'b0);
            end
            else if (pick < 80)
            begin
                make_frame(random_words(), 0, 1'b0, 1'b1);
            end
            else if (pick < 90)
            begin
                line_buf.delete();
                repeat ($urandom_range(0, 45)) line_buf.push_back(random_non_separator());
                line_buf.push_back(htfr_pkg::SEPARATOR);
            end
            else if (pick < 97)
            begin
                line_buf.delete();
                repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
                line_buf.push_back(htfr_pkg::SEPARATOR);
            end
            else
            begin
                line_buf.delete();
                repeat ($urandom_range(LINE_LIMIT, LINE_LIMIT + 6))
                    line_buf.push_back(random_non_separator());
                line_buf.push_back(htfr_pkg::SEPARATOR);
            end
            send_line();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct  = 16;
        sink_idle_pct = 46;
        test_good_frames();
        test_odd_characters();
        test_bad_checksum();
        test_wrong_length();
        test_overlong_line();
        test_random_traffic(RANDOM_BYTES);

        src_idle_pct  = 46;
        sink_idle_pct = 16;
        test_random_traffic(RANDOM_BYTES);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(RANDOM_BYTES);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Sent %0d bytes: %0d ok, %0d bad-checksum, %0d wrong-length reports;",
                 bytes_sent, n_ok, n_bad_sum, n_wrong_len);
        $display("%0d overlong lines were dropped, %0d mismatches seen.",
                 n_dropped, error_count);
        if (error_count == 0)
        begin
            $display("hex_telemetry_frame_receiver_top test passed");
        end
        else
        begin
            $display("hex_telemetry_frame_receiver_top test failed");
        end
        $finish;
    end

endmodule
